// ----- hw/rtl/svg_pkg.sv -----
package svg_pkg;

	localparam int CNT_W           = 8;
	localparam int IDX_W           = 8;
	localparam int RADIUS_W        = 24;
	localparam int PHASE_W         = 32;
	localparam int DIV_W           = CNT_W + PHASE_W;
	localparam int XY_W            = 33;
	localparam int Z_W             = 33;
	localparam int POS_W           = 25;
	localparam int CFG_IDX_W       = 8;
	localparam int CFG_DATA_W      = 24;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int MAX_DIV_DEF     = 255;
	localparam int TRIG_STAGES_DEF = 16;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS   = 8'd0,
		REG_SEGMENTS = 8'd1,
		REG_RINGS    = 8'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] rem;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic [1:0]             quad;
	} rot_t;

	typedef struct packed {
		logic signed [XY_W-1:0] c;
		logic signed [XY_W-1:0] s;
	} cs_t;

	function automatic logic [31:0] atan_of(input int i);
		logic [31:0] v;
		unique case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// Folds the phase into the quarter turn around zero and loads the rotator.
	function automatic rot_t rot_init(input logic [PHASE_W-1:0] ph);
		rot_t        r;
		logic [31:0] sh;
		logic [31:0] zr;
		sh = ph + 32'h2000_0000;
		zr = ph - {sh[31:30], 30'd0};
		r.x = CORDIC_GAIN;
		r.y = '0;
		r.z = Z_W'($signed(zr));
		r.quad = sh[31:30];
		return r;
	endfunction

	function automatic cs_t quad_map(input rot_t r);
		cs_t o;
		unique case (r.quad)
			2'd0: begin o.c = r.x;  o.s = r.y;  end
			2'd1: begin o.c = -r.y; o.s = r.x;  end
			2'd2: begin o.c = -r.x; o.s = -r.y; end
			default: begin o.c = r.y; o.s = -r.x; end
		endcase
		return o;
	endfunction

	function automatic logic signed [XY_W-1:0] mul_q30(input logic signed [XY_W-1:0] a,
		input logic signed [XY_W-1:0] b);
		logic signed [2*XY_W-1:0] p;
		p = (2*XY_W)'(a) * (2*XY_W)'(b) + (2*XY_W)'(64'sd1 <<< 29);
		return XY_W'(p >>> 30);
	endfunction

endpackage

// ----- hw/rtl/svg_div_cell.sv -----
module svg_div_cell
	import svg_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [CNT_W-1:0] cnt,
	input  div_lane_t        d_i,
	output div_lane_t        d_o
);

	logic [CNT_W:0] trial;
	logic           ge;
	div_lane_t      nxt;

	always_comb begin
		trial = {d_i.rem, d_i.num[DIV_W-1]};
		ge = trial >= {1'b0, cnt};
		nxt.rem = ge ? CNT_W'(trial - {1'b0, cnt}) : trial[CNT_W-1:0];
		nxt.num = {d_i.num[DIV_W-2:0], 1'b0};
		nxt.quo = {d_i.quo[DIV_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= nxt;
		end
	end

endmodule

// ----- hw/rtl/svg_cordic_cell.sv -----
module svg_cordic_cell
	import svg_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic en,
	input  rot_t r_i,
	output rot_t r_o
);

	localparam logic signed [Z_W-1:0] ANGLE = Z_W'(atan_of(IDX));

	rot_t nxt;

	always_comb begin
		nxt.quad = r_i.quad;
		if (!r_i.z[Z_W-1]) begin
			nxt.x = r_i.x - (r_i.y >>> IDX);
			nxt.y = r_i.y + (r_i.x >>> IDX);
			nxt.z = r_i.z - ANGLE;
		end else begin
			nxt.x = r_i.x + (r_i.y >>> IDX);
			nxt.y = r_i.y - (r_i.x >>> IDX);
			nxt.z = r_i.z + ANGLE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_o <= nxt;
		end
	end

endmodule

// ----- hw/rtl/uv_sphere_vertex_generator.sv -----
// Turns a grid point (ring, segment) into one UV-sphere vertex: position, unit normal and
// texture coordinates in fixed point. The block is fully pipelined and takes one grid
// point per clock while the output is not held off; a vertex passes through the
// bit-per-cell phase dividers (40 cells), the CORDIC rotator chain (one cell per
// iteration), one product stage, one scaling stage and the output register. When the
// output is held off the whole pipeline freezes, and s_tready is driven combinationally
// from m_tready and m_tvalid. Write the configuration registers only while no vertex is
// in flight.
module uv_sphere_vertex_generator
	import svg_pkg::*;
#(
	parameter int FRAC_BITS     = FRAC_BITS_DEF,
	parameter int MAX_DIVISIONS = MAX_DIV_DEF,
	parameter int TRIG_STAGES   = TRIG_STAGES_DEF,
	localparam int NORM_W = FRAC_BITS + 2,
	localparam int TEX_W  = FRAC_BITS + 1,
	localparam int OUT_BITS = 3 * POS_W + 3 * NORM_W + 2 * TEX_W,
	localparam int OUT_W  = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// ring_index [7:0], segment_index [15:8]
	input  logic [2*IDX_W-1:0]    s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, zero fill
	output logic [OUT_W-1:0]      m_tdata
);

	localparam int LAT  = DIV_W + TRIG_STAGES + 3;
	localparam int PR_W = RADIUS_W + 1 + XY_W;
	localparam logic signed [PR_W-1:0] PR_HALF = PR_W'(64'sd1 <<< 29);
	localparam logic signed [XY_W-1:0] N_HALF  = XY_W'(64'sd1 <<< (29 - FRAC_BITS));
	localparam logic signed [XY_W-1:0] N_ONE   = XY_W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [PR_W-1:0] P_MAX   = PR_W'(64'sd16777215);
	localparam logic signed [PR_W-1:0] P_MIN   = -PR_W'(64'sd16777216);

	logic [RADIUS_W-1:0] radius_q;
	logic [CNT_W-1:0]    segs_q;
	logic [CNT_W-1:0]    rings_q;
	logic [CNT_W-1:0]    segs;
	logic [CNT_W-1:0]    rings;

	logic           adv;
	logic [LAT-1:0] vld_q;

	logic [IDX_W-1:0] ring_in;
	logic [IDX_W-1:0] seg_in;
	logic [CNT_W-1:0] ring_s;
	logic [CNT_W-1:0] seg_s;

	div_lane_t lat_c [DIV_W+1];
	div_lane_t lon_c [DIV_W+1];
	div_lane_t tu_c  [DIV_W+1];
	div_lane_t tv_c  [DIV_W+1];

	rot_t lat_r [TRIG_STAGES+1];
	rot_t lon_r [TRIG_STAGES+1];
	logic [TEX_W-1:0] tu_d [TRIG_STAGES+1];
	logic [TEX_W-1:0] tv_d [TRIG_STAGES+1];

	logic [PHASE_W-1:0] lat_ph;
	cs_t lat_cs;
	cs_t lon_cs;

	logic signed [XY_W-1:0] d_s1 [3];
	logic [TEX_W-1:0]       tu_s1;
	logic [TEX_W-1:0]       tv_s1;
	logic signed [PR_W-1:0] prod_s2 [3];
	logic [NORM_W-1:0]      norm_s2 [3];
	logic [TEX_W-1:0]       tu_s2;
	logic [TEX_W-1:0]       tv_s2;

	logic signed [XY_W-1:0] nv [3];
	logic signed [PR_W-1:0] pv [3];
	logic [POS_W-1:0]       pos_q [3];
	logic [NORM_W-1:0]      norm_q [3];
	logic [TEX_W-1:0]       tu_q;
	logic [TEX_W-1:0]       tv_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_W'(65536);
			segs_q <= CNT_W'(32);
			rings_q <= CNT_W'(16);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RADIUS:   radius_q <= cfg_data[RADIUS_W-1:0];
				REG_SEGMENTS: segs_q <= cfg_data[CNT_W-1:0];
				REG_RINGS:    rings_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		segs = segs_q;
		if (segs_q == '0) begin
			segs = CNT_W'(1);
		end else if (32'(segs_q) > 32'(MAX_DIVISIONS)) begin
			segs = CNT_W'(MAX_DIVISIONS);
		end
		rings = rings_q;
		if (rings_q == '0) begin
			rings = CNT_W'(1);
		end else if (32'(rings_q) > 32'(MAX_DIVISIONS)) begin
			rings = CNT_W'(MAX_DIVISIONS);
		end
	end

	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	assign ring_in = s_tdata[IDX_W-1:0];
	assign seg_in = s_tdata[2*IDX_W-1:IDX_W];
	assign ring_s = (ring_in > rings) ? rings : ring_in;
	assign seg_s = (seg_in > segs) ? segs : seg_in;

	always_comb begin
		lat_c[0].rem = '0;
		lat_c[0].quo = '0;
		lat_c[0].num = (DIV_W'(ring_s) << 31) + DIV_W'(rings >> 1);
		lon_c[0].rem = '0;
		lon_c[0].quo = '0;
		lon_c[0].num = (DIV_W'(seg_s) << 32) + DIV_W'(segs >> 1);
		tu_c[0].rem = '0;
		tu_c[0].quo = '0;
		tu_c[0].num = (DIV_W'(seg_s) << FRAC_BITS) + DIV_W'(segs >> 1);
		tv_c[0].rem = '0;
		tv_c[0].quo = '0;
		tv_c[0].num = (DIV_W'(ring_s) << FRAC_BITS) + DIV_W'(rings >> 1);
	end

	for (genvar k = 0; k < DIV_W; k++) begin : g_div
		svg_div_cell u_lat (.clk(clk), .en(adv), .cnt(rings), .d_i(lat_c[k]), .d_o(lat_c[k+1]));
		svg_div_cell u_lon (.clk(clk), .en(adv), .cnt(segs), .d_i(lon_c[k]), .d_o(lon_c[k+1]));
		svg_div_cell u_tu (.clk(clk), .en(adv), .cnt(segs), .d_i(tu_c[k]), .d_o(tu_c[k+1]));
		svg_div_cell u_tv (.clk(clk), .en(adv), .cnt(rings), .d_i(tv_c[k]), .d_o(tv_c[k+1]));
	end

	assign lat_ph = lat_c[DIV_W].quo[PHASE_W-1:0] - 32'h4000_0000;
	assign lat_r[0] = rot_init(lat_ph);
	assign lon_r[0] = rot_init(lon_c[DIV_W].quo[PHASE_W-1:0]);
	assign tu_d[0] = tu_c[DIV_W].quo[TEX_W-1:0];
	assign tv_d[0] = tv_c[DIV_W].quo[TEX_W-1:0];

	for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_rot
		svg_cordic_cell #(.IDX(k)) u_lat (.clk(clk), .en(adv), .r_i(lat_r[k]), .r_o(lat_r[k+1]));
		svg_cordic_cell #(.IDX(k)) u_lon (.clk(clk), .en(adv), .r_i(lon_r[k]), .r_o(lon_r[k+1]));

		always_ff @(posedge clk) begin
			if (adv) begin
				tu_d[k+1] <= tu_d[k];
				tv_d[k+1] <= tv_d[k];
			end
		end
	end

	assign lat_cs = quad_map(lat_r[TRIG_STAGES]);
	assign lon_cs = quad_map(lon_r[TRIG_STAGES]);

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= mul_q30(lat_cs.c, lon_cs.c);
			d_s1[1] <= lat_cs.s;
			d_s1[2] <= mul_q30(lat_cs.c, lon_cs.s);
			tu_s1 <= tu_d[TRIG_STAGES];
			tv_s1 <= tv_d[TRIG_STAGES];
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nv[k] = (d_s1[k] + N_HALF) >>> (30 - FRAC_BITS);
			if (nv[k] > N_ONE) begin
				nv[k] = N_ONE;
			end else if (nv[k] < -N_ONE) begin
				nv[k] = -N_ONE;
			end
			pv[k] = (prod_s2[k] + PR_HALF) >>> 30;
			if (pv[k] > P_MAX) begin
				pv[k] = P_MAX;
			end else if (pv[k] < P_MIN) begin
				pv[k] = P_MIN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				prod_s2[k] <= PR_W'($signed({1'b0, radius_q})) * PR_W'(d_s1[k]);
				norm_s2[k] <= nv[k][NORM_W-1:0];
				pos_q[k] <= pv[k][POS_W-1:0];
				norm_q[k] <= norm_s2[k];
			end
			tu_s2 <= tu_s1;
			tv_s2 <= tv_s1;
			tu_q <= tu_s2;
			tv_q <= tv_s2;
		end
	end

	assign m_tdata = OUT_W'({tv_q, tu_q, norm_q[2], norm_q[1], norm_q[0],
		pos_q[2], pos_q[1], pos_q[0]});

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(lat_c[DIV_W].quo) && $stable(vld_q))
		else $error("pipeline moved while the output was stalled");

	a_tex_u: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> tu_q <= TEX_W'(64'd1 << FRAC_BITS))
		else $error("tex_u above one");

	a_norm_y: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(norm_q[1]) <= $signed(NORM_W'(64'd1 << FRAC_BITS)))
			&& ($signed(norm_q[1]) >= -$signed(NORM_W'(64'd1 << FRAC_BITS))))
		else $error("norm_y outside unit range");

endmodule
